// File: src/kft_pkg.sv
// ----------------------------------------------------------------------------
// kft_pkg: shared types and codes for the key frequency table
// Sequencer state codes and operation codes of the input word.
// ----------------------------------------------------------------------------
`default_nettype none

package kft_pkg;

  // operation field of an input word
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // sequencer state
  typedef logic [1:0] state_t;

  localparam state_t ST_IDLE   = 2'd0;
  localparam state_t ST_SEARCH = 2'd1;
  localparam state_t ST_FINISH = 2'd2;

endpackage

`default_nettype wire

// File: src/kft_in_if.sv
// ----------------------------------------------------------------------------
// kft_in_if: request channel of the key frequency table
// Carries one operation and one key per word, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface kft_in_if #(
  parameter int KEY_WIDTH = 32
);

  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [KEY_WIDTH-1:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);

endinterface

`default_nettype wire

// File: src/kft_out_if.sv
// ----------------------------------------------------------------------------
// kft_out_if: result channel of the key frequency table
// One result word per request, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface kft_out_if #(
  parameter int ENTRIES     = 64,
  parameter int COUNT_WIDTH = 32
);

  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int USED_W = $clog2(ENTRIES + 1);

  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [SLOT_W-1:0]      slot;
  logic [COUNT_WIDTH-1:0] key_count;
  logic                   table_full;
  logic [COUNT_WIDTH-1:0] biggest_count;
  logic [COUNT_WIDTH-1:0] total_count;
  logic [USED_W-1:0]      distinct_entries;

  modport source (output valid, output found, output slot, output key_count,
                  output table_full, output biggest_count, output total_count,
                  output distinct_entries, input ready);
  modport sink   (input valid, input found, input slot, input key_count,
                  input table_full, input biggest_count, input total_count,
                  input distinct_entries, output ready);

endinterface

`default_nettype wire

// File: src/key_frequency_table.sv
// ----------------------------------------------------------------------------
// key_frequency_table: counting table of distinct keys with linear search
//
// in_if carries (operation, key). operation insert counts the key: a stored
// match gets its count bumped (saturating), a new key is appended with
// count 1, and a new key on a full table is dropped with table_full set.
// operation lookup only reports the matching slot and count.
// out_if returns one word per request: found, slot, key_count, table_full
// and the running largest count, total count and number of entries.
//
// The stored keys are scanned in slot order through one registered memory
// read port and one key comparator, one slot per cycle. A request is
// accepted, scanned up to the match or else over all slots in use (the scan
// is skipped on an empty table), and then finished by loading the output
// register. in_if.ready is high only while no request is in progress, so a
// new request is not accepted before the last one has finished.
// The result sits in an output register; the next request is accepted while
// it waits. A stalled receiver holds a finished request in its last step.
// Reset clears the entry count, total and largest count and the handshake;
// the key and count memories are not cleared, only slots in use are read.
// ----------------------------------------------------------------------------
`default_nettype none

module key_frequency_table #(
  parameter int ENTRIES     = 64,
  parameter int KEY_WIDTH   = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  kft_in_if.sink    in_if,
  kft_out_if.source out_if
);

  import kft_pkg::*;

  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int USED_W = $clog2(ENTRIES + 1);

  // sequencer and request registers
  state_t                 state_r, state_nxt;
  logic                   op_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [USED_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [SLOT_W-1:0]      cmp_idx_r;
  logic                   pend_r, pend_nxt;
  logic                   hit_r, hit_nxt;
  logic [SLOT_W-1:0]      where_r, where_nxt;

  // table status
  logic [USED_W-1:0]      used_r, used_nxt;
  logic [COUNT_WIDTH-1:0] total_r, total_nxt;
  logic [COUNT_WIDTH-1:0] biggest_r, biggest_nxt;

  // storage
  logic [KEY_WIDTH-1:0]   key_mem   [ENTRIES];
  logic [COUNT_WIDTH-1:0] count_mem [ENTRIES];
  logic [KEY_WIDTH-1:0]   key_q;
  logic [COUNT_WIDTH-1:0] count_q;

  // output register
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [SLOT_W-1:0]      out_slot_r;
  logic [COUNT_WIDTH-1:0] out_count_r;
  logic                   out_full_r;
  logic [COUNT_WIDTH-1:0] out_biggest_r;
  logic [COUNT_WIDTH-1:0] out_total_r;
  logic [USED_W-1:0]      out_used_r;

  logic                   in_fire;
  logic                   hit_now;
  logic                   last_now;
  logic                   rd_en;
  logic                   fire;
  logic                   is_ins;
  logic                   has_room;
  logic [COUNT_WIDTH-1:0] inc_cnt;
  logic [COUNT_WIDTH-1:0] total_inc;
  logic [COUNT_WIDTH-1:0] res_cnt;
  logic                   res_found;
  logic                   res_full;
  logic [SLOT_W-1:0]      res_slot;
  logic                   counted;
  logic                   key_we;
  logic                   count_we;
  logic [SLOT_W-1:0]      wr_addr;
  logic [COUNT_WIDTH-1:0] wr_count;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;

  // compare stage: key_q holds the stored key of slot cmp_idx_r
  assign hit_now  = pend_r && (key_q == key_r);
  assign last_now = pend_r && (USED_W'(cmp_idx_r) == used_r - USED_W'(1));
  assign rd_en    = (state_r == ST_SEARCH) && !hit_now && (rd_idx_r < used_r);

  // result is loaded once the output register is free
  assign fire = (state_r == ST_FINISH) && (!out_valid_r || out_if.ready);

  // update arithmetic for the finish step
  assign is_ins    = (op_r == OP_INSERT);
  assign has_room  = (used_r < USED_W'(ENTRIES));
  assign inc_cnt   = (count_q == '1) ? count_q : count_q + COUNT_WIDTH'(1);
  assign total_inc = (total_r == '1) ? total_r : total_r + COUNT_WIDTH'(1);

  always_comb begin
    res_found = 1'b0;
    res_full  = 1'b0;
    res_slot  = '0;
    res_cnt   = '0;
    counted   = 1'b0;
    key_we    = 1'b0;
    count_we  = 1'b0;
    wr_addr   = where_r;
    wr_count  = inc_cnt;
    if (is_ins) begin
      if (hit_r) begin
        res_found = 1'b1;
        res_slot  = where_r;
        res_cnt   = inc_cnt;
        counted   = 1'b1;
        count_we  = fire;
      end else if (has_room) begin
        res_slot  = used_r[SLOT_W-1:0];
        res_cnt   = COUNT_WIDTH'(1);
        counted   = 1'b1;
        key_we    = fire;
        count_we  = fire;
        wr_addr   = used_r[SLOT_W-1:0];
        wr_count  = COUNT_WIDTH'(1);
      end else begin
        res_full  = 1'b1;
      end
    end else if (hit_r) begin
      res_found = 1'b1;
      res_slot  = where_r;
      res_cnt   = count_q;
    end
  end

  // table status next values
  always_comb begin
    used_nxt    = used_r;
    total_nxt   = total_r;
    biggest_nxt = biggest_r;
    if (fire && counted) begin
      total_nxt = total_inc;
      if (res_cnt > biggest_r) begin
        biggest_nxt = res_cnt;
      end
      if (!hit_r) begin
        used_nxt = used_r + USED_W'(1);
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    pend_nxt   = pend_r;
    hit_nxt    = hit_r;
    where_nxt  = where_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          rd_idx_nxt = '0;
          pend_nxt   = 1'b0;
          hit_nxt    = 1'b0;
          state_nxt  = (used_r == '0) ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        pend_nxt = rd_en;
        if (rd_en) begin
          rd_idx_nxt = rd_idx_r + USED_W'(1);
        end
        if (hit_now) begin
          hit_nxt   = 1'b1;
          where_nxt = cmp_idx_r;
          state_nxt = ST_FINISH;
        end else if (last_now) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pend_r    <= 1'b0;
      used_r    <= '0;
      total_r   <= '0;
      biggest_r <= '0;
    end else begin
      state_r   <= state_nxt;
      pend_r    <= pend_nxt;
      used_r    <= used_nxt;
      total_r   <= total_nxt;
      biggest_r <= biggest_nxt;
    end
  end

  // request and search payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_if.operation;
      key_r <= in_if.key;
    end
    if (rd_en) begin
      cmp_idx_r <= rd_idx_r[SLOT_W-1:0];
    end
    rd_idx_r <= rd_idx_nxt;
    hit_r    <= hit_nxt;
    where_r  <= where_nxt;
  end

  // key and count memories, registered read
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_r;
    end
    if (rd_en) begin
      key_q <= key_mem[rd_idx_r[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (count_we) begin
      count_mem[wr_addr] <= wr_count;
    end
    if (rd_en) begin
      count_q <= count_mem[rd_idx_r[SLOT_W-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_found_r   <= res_found;
      out_slot_r    <= res_slot;
      out_count_r   <= res_cnt;
      out_full_r    <= res_full;
      out_biggest_r <= biggest_nxt;
      out_total_r   <= total_nxt;
      out_used_r    <= used_nxt;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.found            = out_found_r;
  assign out_if.slot             = out_slot_r;
  assign out_if.key_count        = out_count_r;
  assign out_if.table_full       = out_full_r;
  assign out_if.biggest_count    = out_biggest_r;
  assign out_if.total_count      = out_total_r;
  assign out_if.distinct_entries = out_used_r;

endmodule

`default_nettype wire
